FILE: hdl/i2c_mbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types and constants for the bit-level I2C master sequencer.
// ----------------------------------------------------------------------------
package i2c_mbe_pkg;

  // Width of the action field on the input channel.
  localparam int ACTION_W = 3;
  // Width of the byte fields on both channels.
  localparam int BYTE_W = 8;
  // Width of the bit counter; covers any byte length up to 31 bits.
  localparam int STEP_W = 5;
  // Width of the phase counter within one bit.
  localparam int PHASE_W = 3;
  // Default number of bits shifted per byte command.
  localparam int BITS_PER_BYTE_DEF = 8;

  // Command codes; the action field uses the same encoding, zero is a tick.
  typedef enum logic [ACTION_W-1:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  // Control state of the sequencer that travels between the top and the step logic.
  typedef struct packed {
    cmd_t               cmd;
    logic [PHASE_W-1:0] phase;
    logic [STEP_W-1:0]  step;
    logic               scl;
    logic               sda;
    logic               ack_choice;
    logic               ack_sample;
  } ctrl_t;

endpackage

FILE: hdl/i2c_mbe_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine input channel
// Valid/ready channel that carries one command or tick per transaction.
// ----------------------------------------------------------------------------
interface i2c_mbe_in_if;
  import i2c_mbe_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   data;
  logic                send_ack;
  logic                sda_in;

  modport source (output valid, output action, output data, output send_ack,
                  output sda_in, input ready);
  modport sink   (input valid, input action, input data, input send_ack,
                  input sda_in, output ready);
endinterface

FILE: hdl/i2c_mbe_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine result channel
// Valid/ready channel that carries the bus levels and status of one step.
// ----------------------------------------------------------------------------
interface i2c_mbe_out_if;
  import i2c_mbe_pkg::*;

  logic              valid;
  logic              ready;
  logic              scl;
  logic              sda_out;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] read_data;
  logic              ack_level;

  modport source (output valid, output scl, output sda_out, output busy_res,
                  output done_res, output read_data, output ack_level, input ready);
  modport sink   (input valid, input scl, input sda_out, input busy_res,
                  input done_res, input read_data, input ack_level, output ready);
endinterface

FILE: hdl/i2c_mbe_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine step logic
// Next-state logic for one pin step: command launch, per-command phase
// sequencing, data shifting and acknowledge handling.
// ----------------------------------------------------------------------------
module i2c_mbe_step #(
  parameter int BITS_PER_BYTE = i2c_mbe_pkg::BITS_PER_BYTE_DEF
) (
  input  i2c_mbe_pkg::ctrl_t                  ctrl_cur,
  input  logic [BITS_PER_BYTE-1:0]            shift_cur,
  input  logic [i2c_mbe_pkg::BYTE_W-1:0]      last_cur,
  input  logic [i2c_mbe_pkg::ACTION_W-1:0]    action,
  input  logic [i2c_mbe_pkg::BYTE_W-1:0]      data,
  input  logic                                send_ack,
  input  logic                                sda_in,
  output i2c_mbe_pkg::ctrl_t                  ctrl_nxt,
  output logic [BITS_PER_BYTE-1:0]            shift_nxt,
  output logic [i2c_mbe_pkg::BYTE_W-1:0]      last_nxt,
  output logic                                done
);
  import i2c_mbe_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BITS_PER_BYTE);

  always_comb begin
    ctrl_t              n;
    logic [PHASE_W-1:0] p;
    logic               in_bits;
    logic               fin;

    n         = ctrl_cur;
    shift_nxt = shift_cur;
    last_nxt  = last_cur;
    fin       = 1'b0;

    // Launch a new command only while idle; otherwise the item is a tick.
    if (ctrl_cur.cmd == CMD_IDLE &&
        (action == CMD_START || action == CMD_WRITE ||
         action == CMD_READ  || action == CMD_STOP)) begin
      n.cmd   = cmd_t'(action);
      n.step  = '0;
      n.phase = '0;
      if (action == CMD_WRITE) begin
        shift_nxt = BITS_PER_BYTE'(data);
      end
      if (action == CMD_READ) begin
        shift_nxt    = '0;
        n.ack_choice = send_ack;
      end
    end

    p       = n.phase;
    in_bits = (n.step < LAST_STEP);

    // Phase counter advances by one unless a branch below overrides it.
    if (n.cmd != CMD_IDLE) begin
      n.phase = p + PHASE_W'(1);
    end

    case (n.cmd)
      CMD_START: begin
        if (p == 3'd0) begin
          n.sda = 1'b1;
        end else if (p == 3'd1) begin
          n.scl = 1'b1;
        end else if (p == 3'd3) begin
          n.sda = 1'b0;
        end else if (p == 3'd5) begin
          n.scl = 1'b0;
          fin   = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (in_bits) begin
          // Data bit: drive MSB, raise SCL, hold, lower SCL and shift.
          // The MSB comes from the launched byte on the first step.
          if (p == 3'd0) begin
            n.sda = shift_nxt[BITS_PER_BYTE-1];
          end else if (p == 3'd1) begin
            n.scl = 1'b1;
          end else if (p == 3'd3) begin
            n.scl     = 1'b0;
            shift_nxt = {shift_cur[BITS_PER_BYTE-2:0], 1'b0};
            n.step    = n.step + STEP_W'(1);
            n.phase   = '0;
          end
        end else begin
          // Acknowledge slot: release SDA, clock it and sample the slave.
          if (p == 3'd0) begin
            n.sda = 1'b1;
          end else if (p == 3'd2) begin
            n.scl = 1'b1;
          end else if (p == 3'd4) begin
            n.ack_sample = sda_in;
            n.scl        = 1'b0;
            fin          = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (in_bits) begin
          // Data bit: release SDA, raise SCL, then shift in the line level.
          if (p == 3'd0) begin
            n.sda = 1'b1;
          end else if (p == 3'd2) begin
            n.scl = 1'b1;
          end else if (p == 3'd4) begin
            shift_nxt = {shift_cur[BITS_PER_BYTE-2:0], sda_in};
            n.scl     = 1'b0;
            n.step    = n.step + STEP_W'(1);
            n.phase   = '0;
            if (n.step == LAST_STEP) begin
              last_nxt = BYTE_W'({shift_cur[BITS_PER_BYTE-2:0], sda_in});
            end
          end
        end else begin
          // Master acknowledge slot: drive ACK or NAK and clock it.
          if (p == 3'd0) begin
            n.sda = ~n.ack_choice;
          end else if (p == 3'd2) begin
            n.scl = 1'b1;
          end else if (p == 3'd4) begin
            n.scl = 1'b0;
            fin   = 1'b1;
          end
        end
      end
      CMD_STOP: begin
        if (p == 3'd0) begin
          n.sda = 1'b0;
        end else if (p == 3'd2) begin
          n.scl = 1'b1;
        end else if (p == 3'd4) begin
          n.sda = 1'b1;
          fin   = 1'b1;
        end
      end
      default: begin
        n.phase = p;
      end
    endcase

    // A completed command returns the sequencer to idle.
    if (fin) begin
      n.cmd   = CMD_IDLE;
      n.step  = '0;
      n.phase = '0;
    end

    ctrl_nxt = n;
    done     = fin;
  end

endmodule

FILE: hdl/i2c_master_bit_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine
// Bit-level I2C master: each input transaction performs one pin step of a
// start, write byte, read byte or stop command.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries an action (tick, start, write, read, stop),
//   the byte to write, the acknowledge choice for reads and the sampled SDA
//   level. A command is taken only while the engine is idle; later
//   transactions, normally ticks, walk it through its pin steps.
//   Every input transaction yields exactly one result transaction with the
//   SCL and SDA levels after the step, busy and done flags, the last byte
//   read and the last acknowledge level seen after a write.
//   The result is registered, valid the cycle after acceptance. Throughput
//   is one transaction per cycle, set by the single result register.
//   While the result receiver stalls, the result register holds and the
//   input stays ready only if the held result is taken in the same cycle.
//   Reset releases both bus lines, returns to idle, clears the read byte
//   and sets the acknowledge level to one; the result channel goes empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top #(
  parameter int BITS_PER_BYTE = i2c_mbe_pkg::BITS_PER_BYTE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  i2c_mbe_in_if.sink    in_bus,
  i2c_mbe_out_if.source out_bus
);
  import i2c_mbe_pkg::*;

  ctrl_t                    ctrl_r;
  ctrl_t                    ctrl_nxt;
  logic [BITS_PER_BYTE-1:0] shift_r;
  logic [BITS_PER_BYTE-1:0] shift_nxt;
  logic [BYTE_W-1:0]        last_r;
  logic [BYTE_W-1:0]        last_nxt;
  logic                     done_nxt;
  logic                     in_acc;

  logic                     out_valid_r;
  logic                     out_scl_r;
  logic                     out_sda_r;
  logic                     out_busy_r;
  logic                     out_done_r;
  logic [BYTE_W-1:0]        out_read_r;
  logic                     out_ack_r;

  // Accept while the result register is empty or being drained.
  assign in_bus.ready = ~out_valid_r | out_bus.ready;
  assign in_acc       = in_bus.valid & in_bus.ready;

  // Next-state logic for one pin step.
  i2c_mbe_step #(
    .BITS_PER_BYTE (BITS_PER_BYTE)
  ) u_step (
    .ctrl_cur  (ctrl_r),
    .shift_cur (shift_r),
    .last_cur  (last_r),
    .action    (in_bus.action),
    .data      (in_bus.data),
    .send_ack  (in_bus.send_ack),
    .sda_in    (in_bus.sda_in),
    .ctrl_nxt  (ctrl_nxt),
    .shift_nxt (shift_nxt),
    .last_nxt  (last_nxt),
    .done      (done_nxt)
  );

  // Sequencer state, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.cmd        <= CMD_IDLE;
      ctrl_r.phase      <= '0;
      ctrl_r.step       <= '0;
      ctrl_r.scl        <= 1'b1;
      ctrl_r.sda        <= 1'b1;
      ctrl_r.ack_choice <= 1'b0;
      ctrl_r.ack_sample <= 1'b1;
      shift_r           <= '0;
      last_r            <= '0;
    end else if (in_acc) begin
      ctrl_r  <= ctrl_nxt;
      shift_r <= shift_nxt;
      last_r  <= last_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_scl_r  <= ctrl_nxt.scl;
      out_sda_r  <= ctrl_nxt.sda;
      out_busy_r <= (ctrl_nxt.cmd != CMD_IDLE);
      out_done_r <= done_nxt;
      out_read_r <= last_nxt;
      out_ack_r  <= ctrl_nxt.ack_sample;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.scl       = out_scl_r;
  assign out_bus.sda_out   = out_sda_r;
  assign out_bus.busy_res  = out_busy_r;
  assign out_bus.done_res  = out_done_r;
  assign out_bus.read_data = out_read_r;
  assign out_bus.ack_level = out_ack_r;

  // A completing step always leaves the engine idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_busy_r)
    else $error("done reported while still busy");

  // A running command is never replaced by another one.
  a_cmd_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ctrl_r.cmd != CMD_IDLE |=>
      ctrl_r.cmd == $past(ctrl_r.cmd) || ctrl_r.cmd == CMD_IDLE)
    else $error("running command replaced");

  // Without an accepted transaction the sequencer does not move.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(ctrl_r) && $stable(shift_r) && $stable(last_r))
    else $error("sequencer state changed without a transaction");

  // The phase counter never passes the last step of a start command.
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.phase <= 3'd5)
    else $error("phase counter out of range");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives pin-step transactions into the bit engine and checks every result
// transaction against a cycle-free model of the start, write, read and stop
// sequences. A short directed table runs first, then well-formed bus
// sequences with random content, noise and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import i2c_mbe_pkg::*;

  localparam int NBITS        = BITS_PER_BYTE_DEF;
  localparam int RANDOM_ITEMS = 1460;
  localparam int DRAIN_EVERY  = 400;

  // Action codes beyond the command set; zero doubles as the tick.
  localparam logic [ACTION_W-1:0] ACT_TICK      = CMD_IDLE;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_MID = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI  = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data;
    logic                send_ack;
    logic                sda_in;
  } bus_item_t;

  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rdata;
    logic              ack;
  } step_result_t;

  // One row of the directed table: an item, how often it repeats, and an
  // optional typed-in result that replaces the model's prediction.
  typedef struct packed {
    bus_item_t    item;
    logic [7:0]   reps;
    logic         typed;
    step_result_t want;
  } dir_row_t;

  // Both lines released, idle, no byte read, no acknowledge seen.
  localparam step_result_t IDLE_RES = '{scl: 1'b1, sda: 1'b1, busy: 1'b0,
                                        done: 1'b0, rdata: 8'h00, ack: 1'b1};

  localparam int DIR_ROWS = 19;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // Idle after reset: ticks and undefined actions change nothing.
    '{'{ACT_TICK,     8'h00, 1'b0, 1'b0}, 8'd1,  1'b1, IDLE_RES},
    '{'{ACT_UNDEF_LO, 8'hFF, 1'b1, 1'b1}, 8'd1,  1'b1, IDLE_RES},
    '{'{ACT_UNDEF_HI, 8'hA5, 1'b0, 1'b0}, 8'd1,  1'b1, IDLE_RES},
    // Start condition.
    '{'{CMD_START,    8'h00, 1'b0, 1'b0}, 8'd1,  1'b0, '0},
    '{'{ACT_TICK,     8'h00, 1'b0, 1'b0}, 8'd5,  1'b0, '0},
    // Write all ones, acknowledged; a read command mid-write is ignored.
    '{'{CMD_WRITE,    8'hFF, 1'b0, 1'b0}, 8'd1,  1'b0, '0},
    '{'{CMD_READ,     8'h00, 1'b1, 1'b0}, 8'd1,  1'b0, '0},
    '{'{ACT_TICK,     8'h00, 1'b0, 1'b0}, 8'd35, 1'b0, '0},
    // Read all ones and answer with ACK, leaving SDA low.
    '{'{CMD_READ,     8'h00, 1'b1, 1'b1}, 8'd1,  1'b0, '0},
    '{'{ACT_TICK,     8'h00, 1'b0, 1'b1}, 8'd44, 1'b0, '0},
    // Repeated start right after the ACK.
    '{'{CMD_START,    8'h00, 1'b0, 1'b0}, 8'd1,  1'b0, '0},
    '{'{ACT_TICK,     8'h00, 1'b0, 1'b0}, 8'd5,  1'b0, '0},
    // Write all zeros, not acknowledged.
    '{'{CMD_WRITE,    8'h00, 1'b0, 1'b1}, 8'd1,  1'b0, '0},
    '{'{ACT_TICK,     8'hFF, 1'b1, 1'b1}, 8'd36, 1'b0, '0},
    // Read all zeros and answer with NAK.
    '{'{CMD_READ,     8'h00, 1'b0, 1'b0}, 8'd1,  1'b0, '0},
    '{'{ACT_TICK,     8'h00, 1'b0, 1'b0}, 8'd44, 1'b0, '0},
    // Stop, stepped by undefined actions.
    '{'{CMD_STOP,     8'h00, 1'b0, 1'b0}, 8'd1,  1'b0, '0},
    '{'{ACT_UNDEF_MID, 8'h5A, 1'b1, 1'b1}, 8'd4, 1'b0, '0},
    '{'{ACT_TICK,     8'h00, 1'b0, 1'b0}, 8'd1,  1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  i2c_mbe_in_if  in_ch();
  i2c_mbe_out_if out_ch();

  i2c_master_bit_engine_top #(.BITS_PER_BYTE(NBITS)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bus model state.
  logic              m_scl;
  logic              m_sda;
  cmd_t              m_cmd;
  int                m_bit;
  int                m_phase;
  logic [NBITS-1:0]  m_shift;
  logic              m_ack_choice;
  logic              m_ack_sample;
  logic [BYTE_W-1:0] m_last_read;

  step_result_t pending_steps[$];
  int           mismatch_count = 0;
  int           results_seen = 0;
  int           tx_burst = 0;
  int           rx_burst = 0;

  // Advances the bus model by one item and returns the levels after the step.
  function automatic step_result_t advance_bus_model(bus_item_t it);
    step_result_t r;
    logic         fin;
    logic         adv;
    int           p;
    fin = 1'b0;
    adv = 1'b1;
    if (m_cmd == CMD_IDLE && it.action >= CMD_START && it.action <= CMD_STOP) begin
      m_cmd   = cmd_t'(it.action);
      m_bit   = 0;
      m_phase = 0;
      if (m_cmd == CMD_WRITE) m_shift = NBITS'(it.data);
      if (m_cmd == CMD_READ) begin
        m_shift      = '0;
        m_ack_choice = it.send_ack;
      end
    end
    if (m_cmd != CMD_IDLE) begin
      p = m_phase;
      case (m_cmd)
        CMD_START: begin
          if (p == 0) m_sda = 1'b1;
          else if (p == 1) m_scl = 1'b1;
          else if (p == 3) m_sda = 1'b0;
          else if (p == 5) begin
            m_scl = 1'b0;
            fin   = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (m_bit < NBITS) begin
            // Data bits, MSB first: set SDA, raise SCL, delay, lower SCL.
            if (p == 0) m_sda = m_shift[NBITS-1];
            else if (p == 1) m_scl = 1'b1;
            else if (p == 3) begin
              m_scl   = 1'b0;
              m_shift = m_shift << 1;
              m_bit++;
              m_phase = 0;
              adv     = 1'b0;
            end
          end else begin
            // Acknowledge slot: release SDA and sample the slave's answer.
            if (p == 0) m_sda = 1'b1;
            else if (p == 2) m_scl = 1'b1;
            else if (p == 4) begin
              m_ack_sample = it.sda_in;
              m_scl        = 1'b0;
              fin          = 1'b1;
            end
          end
        end
        CMD_READ: begin
          if (m_bit < NBITS) begin
            if (p == 0) m_sda = 1'b1;
            else if (p == 2) m_scl = 1'b1;
            else if (p == 4) begin
              m_shift = {m_shift[NBITS-2:0], it.sda_in};
              m_scl   = 1'b0;
              m_bit++;
              if (m_bit == NBITS) m_last_read = BYTE_W'(m_shift);
              m_phase = 0;
              adv     = 1'b0;
            end
          end else begin
            // Master answers with ACK (low) or NAK (released).
            if (p == 0) m_sda = m_ack_choice ? 1'b0 : 1'b1;
            else if (p == 2) m_scl = 1'b1;
            else if (p == 4) begin
              m_scl = 1'b0;
              fin   = 1'b1;
            end
          end
        end
        CMD_STOP: begin
          if (p == 0) m_sda = 1'b0;
          else if (p == 2) m_scl = 1'b1;
          else if (p == 4) begin
            m_sda = 1'b1;
            fin   = 1'b1;
          end
        end
        default: adv = 1'b0;
      endcase
      if (fin) begin
        m_cmd   = CMD_IDLE;
        m_bit   = 0;
        m_phase = 0;
      end else if (adv) begin
        m_phase = (p + 1) & 7;
      end
    end
    r.scl   = m_scl;
    r.sda   = m_sda;
    r.busy  = (m_cmd != CMD_IDLE);
    r.done  = fin;
    r.rdata = m_last_read;
    r.ack   = m_ack_sample;
    return r;
  endfunction

  // Idle length: mostly none or short, a few long, with bursts of none.
  function automatic int pick_gap(inout int burst);
    int roll;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_step(step_result_t got, step_result_t want);
    if (got.scl !== want.scl)
      report_mismatch($sformatf("scl got %0b expected %0b", got.scl, want.scl));
    if (got.sda !== want.sda)
      report_mismatch($sformatf("sda_out got %0b expected %0b", got.sda, want.sda));
    if (got.busy !== want.busy)
      report_mismatch($sformatf("busy_res got %0b expected %0b", got.busy, want.busy));
    if (got.done !== want.done)
      report_mismatch($sformatf("done_res got %0b expected %0b", got.done, want.done));
    if (got.rdata !== want.rdata)
      report_mismatch($sformatf("read_data got %h expected %h", got.rdata, want.rdata));
    if (got.ack !== want.ack)
      report_mismatch($sformatf("ack_level got %0b expected %0b", got.ack, want.ack));
  endtask

  // Sends one transaction after an optional idle stretch, then records the
  // predicted result once the engine has accepted it.
  task automatic send_item(bus_item_t it, int gap, bit drain, bit typed,
                           step_result_t typed_res);
    step_result_t res;
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain && pending_steps.size() != 0) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= it.action;
    in_ch.data     <= it.data;
    in_ch.send_ack <= it.send_ack;
    in_ch.sda_in   <= it.sda_in;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    res = advance_bus_model(it);
    pending_steps.push_back(typed ? typed_res : res);
  endtask

  // Result receiver with random stalls.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap(rx_burst);
        out_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    step_result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{scl: out_ch.scl, sda: out_ch.sda_out, busy: out_ch.busy_res,
              done: out_ch.done_res, rdata: out_ch.read_data, ack: out_ch.ack_level};
      if (pending_steps.size() == 0) begin
        report_mismatch("result transaction with no expectation pending");
      end else begin
        check_step(got, pending_steps.pop_front());
      end
      results_seen++;
    end
  end

  // Stimulus: reset, directed table, random bus sequences, drain, verdict.
  initial begin
    bus_item_t it;
    int        iter;
    int        counted;
    int        wf_state;
    int        wf_bytes;
    bit        busy_before;
    bit        noise;

    m_scl        = 1'b1;
    m_sda        = 1'b1;
    m_cmd        = CMD_IDLE;
    m_bit        = 0;
    m_phase      = 0;
    m_shift      = '0;
    m_ack_choice = 1'b0;
    m_ack_sample = 1'b1;
    m_last_read  = '0;
    wf_state     = 0;
    wf_bytes     = 0;
    counted      = 0;
    iter         = 0;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= ACT_TICK;
    in_ch.data     <= '0;
    in_ch.send_ack <= 1'b0;
    in_ch.sda_in   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int k = 0; k < int'(DIR_TABLE[r].reps); k++) begin
        send_item(DIR_TABLE[r].item, pick_gap(tx_burst), 1'b0,
                  DIR_TABLE[r].typed, DIR_TABLE[r].want);
      end
    end

    // Random part: mostly well-formed start / address / bytes / stop
    // sequences, with random commands and ignored actions mixed in.
    while (counted < RANDOM_ITEMS) begin
      busy_before = (m_cmd != CMD_IDLE);
      noise       = 1'b0;
      if (!busy_before) begin
        if ($urandom_range(0, 9) == 0) begin
          noise     = 1'b1;
          it.action = ($urandom_range(0, 1) == 0) ? ACT_TICK
                      : 3'(ACT_UNDEF_LO + $urandom_range(0, 2));
        end else if ($urandom_range(0, 4) == 0) begin
          it.action = 3'($urandom_range(int'(CMD_START), int'(CMD_STOP)));
        end else begin
          case (wf_state)
            0: begin
              it.action = CMD_START;
              wf_state  = 1;
            end
            1: begin
              it.action = CMD_WRITE;
              wf_bytes  = $urandom_range(1, 3);
              wf_state  = 2;
            end
            default: begin
              if (wf_bytes > 0) begin
                it.action = ($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ;
                wf_bytes--;
              end else if ($urandom_range(0, 3) == 0) begin
                it.action = CMD_START;
                wf_state  = 1;
              end else begin
                it.action = CMD_STOP;
                wf_state  = 0;
              end
            end
          endcase
        end
      end else begin
        // A running command: ticks, sometimes an action it must ignore.
        it.action = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(1, 7)) : ACT_TICK;
      end
      it.data     = 8'($urandom);
      it.send_ack = 1'($urandom);
      it.sda_in   = 1'($urandom);
      send_item(it, pick_gap(tx_burst), (iter % DRAIN_EVERY) == 0, 1'b0, '0);
      if (!noise) counted++;
      iter++;
    end
    in_ch.valid <= 1'b0;

    while (pending_steps.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("i2c_master_bit_engine_top: match");
    end else begin
      $display("i2c_master_bit_engine_top: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("i2c_master_bit_engine_top: mismatch");
    $finish;
  end

endmodule
